// ===== rtl/core/stream_frame_header_parser_macros.svh =====
// assertion macros for the stream frame header parser
// expects a clock named clk and an active high reset named rst in the using module
`ifndef STREAM_FRAME_HEADER_PARSER_MACROS_SVH
`define STREAM_FRAME_HEADER_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
`define SFHP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sfhp assertion failed");
`define SFHP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("sfhp assertion failed");
`else
`define SFHP_ASSERT(label, prop)
`define SFHP_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/core/sfhp_pkg.sv =====
// shared types and constants of the stream frame header parser
// used by sfhp_parse and stream_frame_header_parser, no dependencies
package sfhp_pkg;

  localparam int VALUE_W = 62;
  localparam int LEN_W   = 16;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // bit positions of the type byte flags
  localparam int FLAG_FIN = 0;
  localparam int FLAG_LEN = 1;
  localparam int FLAG_OFF = 2;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_SID  = 6'b000010,
    PH_OFF  = 6'b000100,
    PH_LEN  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic               has;
    logic [1:0]         kind;
    logic [VALUE_W-1:0] sid;
    logic [VALUE_W-1:0] off;
    logic [VALUE_W-1:0] plen;
    logic               fin;
    logic               lg;
    logic [7:0]         pbyte;
    logic               fend;
    logic [LEN_W-1:0]   consumed;
  } result_t;

endpackage

// ===== rtl/core/sfhp_parse.sv =====
// per byte parse state of the stream frame header parser and the result it produces
// depends on sfhp_pkg
module sfhp_parse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [7:0]                  in_byte,
  input  logic                        buffer_start,
  input  logic [sfhp_pkg::LEN_W-1:0]  buffer_length,
  output sfhp_pkg::result_t           res
);

  sfhp_pkg::phase_t                 phase, phase_next;
  logic [sfhp_pkg::VALUE_W-1:0]     acc, acc_next;
  logic [2:0]                       left, left_next;
  logic                             started, started_next;
  logic [2:0]                       flags, flags_next;
  logic [sfhp_pkg::VALUE_W-1:0]     sid, sid_next;
  logic [sfhp_pkg::VALUE_W-1:0]     off, off_next;
  logic [sfhp_pkg::LEN_W-1:0]       pay_left, pay_left_next;
  logic [sfhp_pkg::LEN_W-1:0]       pos, pos_next;
  logic [sfhp_pkg::LEN_W-1:0]       blen, blen_next;

  logic [sfhp_pkg::LEN_W-1:0]       pos_inc;
  logic [sfhp_pkg::LEN_W-1:0]       remain;
  logic [sfhp_pkg::VALUE_W-1:0]     acc_upd;
  logic [2:0]                       left_upd;
  logic                             fail_now;
  logic                             hdr_now;
  logic                             start_vi;
  sfhp_pkg::phase_t                 vi_phase;
  logic [sfhp_pkg::LEN_W-1:0]       hdr_len;
  logic                             hdr_lg;

  assign pos_inc = pos + sfhp_pkg::LEN_W'(1);

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    left_next     = left;
    started_next  = started;
    flags_next    = flags;
    sid_next      = sid;
    off_next      = off;
    pay_left_next = pay_left;
    pos_next      = pos;
    blen_next     = blen;
    res           = '0;
    fail_now      = 1'b0;
    hdr_now       = 1'b0;
    start_vi      = 1'b0;
    vi_phase      = sfhp_pkg::PH_SID;
    hdr_len       = '0;
    hdr_lg        = 1'b0;
    acc_upd       = '0;
    left_upd      = '0;
    remain        = blen - pos_inc;

    if (buffer_start) begin
      blen_next     = buffer_length;
      sid_next      = '0;
      off_next      = '0;
      pay_left_next = '0;
      flags_next    = in_byte[2:0];
      pos_next      = sfhp_pkg::LEN_W'(1);
      if (buffer_length <= sfhp_pkg::LEN_W'(1)) begin
        fail_now = 1'b1;
      end else begin
        start_vi = 1'b1;
        vi_phase = sfhp_pkg::PH_SID;
      end
    end else begin
      unique case (phase)
        sfhp_pkg::PH_SID, sfhp_pkg::PH_OFF, sfhp_pkg::PH_LEN: begin
          pos_next = pos_inc;
          if (!started) begin
            acc_upd = {{(sfhp_pkg::VALUE_W-6){1'b0}}, in_byte[5:0]};
            unique case (in_byte[7:6])
              2'd0: left_upd = 3'd0;
              2'd1: left_upd = 3'd1;
              2'd2: left_upd = 3'd3;
              default: left_upd = 3'd7;
            endcase
          end else begin
            acc_upd  = {acc[sfhp_pkg::VALUE_W-9:0], in_byte};
            left_upd = (left != 3'd0) ? left - 3'd1 : 3'd0;
          end
          started_next = 1'b1;
          acc_next     = acc_upd;
          left_next    = left_upd;
          if (left_upd == 3'd0) begin
            priority case (1'b1)
              phase == sfhp_pkg::PH_LEN: begin
                if (acc_upd > {{(sfhp_pkg::VALUE_W-sfhp_pkg::LEN_W){1'b0}}, remain}) begin
                  fail_now = 1'b1;
                end else begin
                  hdr_now = 1'b1;
                  hdr_len = acc_upd[sfhp_pkg::LEN_W-1:0];
                  hdr_lg  = 1'b1;
                end
              end
              phase == sfhp_pkg::PH_SID && flags[sfhp_pkg::FLAG_OFF]: begin
                sid_next = acc_upd;
                start_vi = 1'b1;
                vi_phase = sfhp_pkg::PH_OFF;
              end
              default: begin
                if (phase == sfhp_pkg::PH_SID) begin
                  sid_next = acc_upd;
                end else begin
                  off_next = acc_upd;
                end
                if (flags[sfhp_pkg::FLAG_LEN]) begin
                  start_vi = 1'b1;
                  vi_phase = sfhp_pkg::PH_LEN;
                end else begin
                  hdr_now = 1'b1;
                  hdr_len = remain;
                end
              end
            endcase
          end else if (pos_inc >= blen) begin
            fail_now = 1'b1;
          end
        end
        sfhp_pkg::PH_DATA: begin
          pos_next      = pos_inc;
          pay_left_next = (pay_left != '0) ? pay_left - sfhp_pkg::LEN_W'(1) : '0;
          res.has   = 1'b1;
          res.kind  = sfhp_pkg::KIND_PAYLOAD;
          res.pbyte = in_byte;
          if (pay_left_next == '0) begin
            res.fend     = 1'b1;
            res.consumed = pos_inc;
            phase_next   = sfhp_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end

    if (start_vi) begin
      if (pos_next >= blen_next) begin
        fail_now = 1'b1;
      end else begin
        phase_next   = vi_phase;
        started_next = 1'b0;
        left_next    = 3'd0;
        acc_next     = '0;
      end
    end

    if (fail_now) begin
      res          = '0;
      res.has      = 1'b1;
      res.kind     = sfhp_pkg::KIND_ERROR;
      res.fend     = 1'b1;
      res.consumed = pos_next;
      phase_next   = sfhp_pkg::PH_DONE;
    end else if (hdr_now) begin
      res.has      = 1'b1;
      res.kind     = sfhp_pkg::KIND_HEADER;
      res.sid      = sid_next;
      res.off      = off_next;
      res.plen     = {{(sfhp_pkg::VALUE_W-sfhp_pkg::LEN_W){1'b0}}, hdr_len};
      res.fin      = flags[sfhp_pkg::FLAG_FIN];
      res.lg       = hdr_lg;
      pay_left_next = hdr_len;
      if (hdr_len == '0) begin
        res.fend     = 1'b1;
        res.consumed = pos_next;
        phase_next   = sfhp_pkg::PH_DONE;
      end else begin
        phase_next   = sfhp_pkg::PH_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= sfhp_pkg::PH_IDLE;
      acc      <= '0;
      left     <= '0;
      started  <= 1'b0;
      flags    <= '0;
      sid      <= '0;
      off      <= '0;
      pay_left <= '0;
      pos      <= '0;
      blen     <= '0;
    end else if (advance) begin
      phase    <= phase_next;
      acc      <= acc_next;
      left     <= left_next;
      started  <= started_next;
      flags    <= flags_next;
      sid      <= sid_next;
      off      <= off_next;
      pay_left <= pay_left_next;
      pos      <= pos_next;
      blen     <= blen_next;
    end
  end

endmodule

// ===== rtl/core/stream_frame_header_parser.sv =====
// Stream frame header parser. Takes one buffer byte per transfer and gives a
// header result, then one result per payload byte, or an error result when the
// buffer is too short. Each byte is parsed against the running state in the
// cycle it is accepted, and its result appears in the output register on the
// next cycle, so a byte can be taken in every cycle while that register is
// free or being drained.
// Depends on sfhp_pkg, sfhp_parse and stream_frame_header_parser_macros.svh.
`include "stream_frame_header_parser_macros.svh"

module stream_frame_header_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          buffer_start,
  input  logic [sfhp_pkg::LEN_W-1:0]    buffer_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic [sfhp_pkg::VALUE_W-1:0]  stream_number,
  output logic [sfhp_pkg::VALUE_W-1:0]  byte_offset,
  output logic [sfhp_pkg::VALUE_W-1:0]  payload_length,
  output logic                          fin_flag,
  output logic                          length_given,
  output logic [7:0]                    payload_byte,
  output logic                          frame_end,
  output logic [sfhp_pkg::LEN_W-1:0]    consumed_bytes
);

  sfhp_pkg::result_t res;
  logic              advance;

  assign in_stall = out_valid & out_stall;
  assign advance  = in_valid & ~in_stall;

  sfhp_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_byte       (in_byte),
    .buffer_start  (buffer_start),
    .buffer_length (buffer_length),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.has;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && res.has) begin
      kind           <= res.kind;
      stream_number  <= res.sid;
      byte_offset    <= res.off;
      payload_length <= res.plen;
      fin_flag       <= res.fin;
      length_given   <= res.lg;
      payload_byte   <= res.pbyte;
      frame_end      <= res.fend;
      consumed_bytes <= res.consumed;
    end
  end

  `SFHP_ASSERT(a_error_ends_frame,
    out_valid && kind == sfhp_pkg::KIND_ERROR |-> frame_end && consumed_bytes != '0)
  `SFHP_ASSERT(a_consumed_only_at_end, out_valid && !frame_end |-> consumed_bytes == '0)
  `SFHP_ASSERT(a_payload_no_header,
    out_valid && kind == sfhp_pkg::KIND_PAYLOAD |->
      stream_number == '0 && payload_length == '0 && !length_given)
  `SFHP_ASSERT_ALWAYS(a_reset_clears_valid, rst |=> !out_valid)

endmodule

// ===== sim/stream_frame_header_parser_test.sv =====
// testbench for stream_frame_header_parser: random framed buffers, random idling
// on both sides, results checked field by field against a built-in parser model
// depends on sfhp_pkg and the stream_frame_header_parser rtl
module stream_frame_header_parser_test;
  import sfhp_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic [VALUE_W-1:0] sid;
    logic [VALUE_W-1:0] off;
    logic [VALUE_W-1:0] plen;
    logic               fin;
    logic               lg;
    logic [7:0]         pbyte;
    logic               fend;
    logic [LEN_W-1:0]   consumed;
  } frame_result_t;

  class frame_scoreboard;
    phase_t              phase;
    logic [VALUE_W-1:0]  acc;
    logic [VALUE_W-1:0]  sid_held;
    logic [VALUE_W-1:0]  off_held;
    logic [VALUE_W-1:0]  data_left;
    int                  bytes_left;
    logic [2:0]          flags;
    logic [LEN_W-1:0]    pos;
    logic [LEN_W-1:0]    blen;
    bit                  started;
    frame_result_t       due_results[$];
    int                  errors;

    function new();
      phase      = PH_IDLE;
      acc        = '0;
      sid_held   = '0;
      off_held   = '0;
      data_left  = '0;
      bytes_left = 0;
      flags      = '0;
      pos        = '0;
      blen       = '0;
      started    = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void emit(logic [1:0] k, logic [VALUE_W-1:0] s, logic [VALUE_W-1:0] o,
                       logic [VALUE_W-1:0] p, logic f, logic l, logic [7:0] pb,
                       logic e, logic [LEN_W-1:0] c);
      due_results.push_back({k, s, o, p, f, l, pb, e, c});
    endfunction

    function void raise_error();
      emit(KIND_ERROR, '0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b1, pos);
      phase = PH_DONE;
    endfunction

    function void open_field(phase_t nxt);
      if (pos >= blen) begin
        raise_error();
      end else begin
        phase      = nxt;
        started    = 1'b0;
        bytes_left = 0;
        acc        = '0;
      end
    endfunction

    function void emit_header(logic [VALUE_W-1:0] plen, logic lg);
      logic fend;
      fend = (plen == 0);
      emit(KIND_HEADER, sid_held, off_held, plen, flags[FLAG_FIN], lg, 8'h00, fend,
           fend ? pos : '0);
      data_left = plen;
      phase = fend ? PH_DONE : PH_DATA;
    endfunction

    function void close_field();
      logic [VALUE_W-1:0] remain;
      remain = VALUE_W'(blen) - VALUE_W'(pos);
      if (phase == PH_SID) begin
        sid_held = acc;
        if (flags[FLAG_OFF]) begin
          open_field(PH_OFF);
          return;
        end
      end else if (phase == PH_OFF) begin
        off_held = acc;
      end else begin
        if (acc > remain) raise_error();
        else emit_header(acc, 1'b1);
        return;
      end
      if (flags[FLAG_LEN]) open_field(PH_LEN);
      else emit_header(remain, 1'b0);
    endfunction

    // returns 1 when the byte belongs to a buffer being parsed
    function bit take_byte(logic [7:0] b, logic st, logic [LEN_W-1:0] len);
      logic fend;
      if (st) begin
        blen      = len;
        sid_held  = '0;
        off_held  = '0;
        data_left = '0;
        flags     = b[2:0];
        pos       = 1;
        if (blen <= 1) raise_error();
        else open_field(PH_SID);
        return 1'b1;
      end
      case (phase)
        PH_SID, PH_OFF, PH_LEN: begin
          pos++;
          if (!started) begin
            started    = 1'b1;
            bytes_left = (1 << b[7:6]) - 1;
            acc        = VALUE_W'(b[5:0]);
          end else begin
            acc = {acc[VALUE_W-9:0], b};
            if (bytes_left > 0) bytes_left--;
          end
          if (bytes_left == 0) close_field();
          else if (pos >= blen) raise_error();
          return 1'b1;
        end
        PH_DATA: begin
          pos++;
          if (data_left > 0) data_left--;
          fend = (data_left == 0);
          emit(KIND_PAYLOAD, '0, '0, '0, 1'b0, 1'b0, b, fend, fend ? pos : '0);
          if (fend) phase = PH_DONE;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void match(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (want_v !== got_v) begin
        $error("%s: expected %0h, actual %0h", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (due_results.size() == 0) begin
        $error("result with none expected: kind %0d", got.kind);
        errors++;
        return;
      end
      want = due_results.pop_front();
      match("kind", want.kind, got.kind);
      match("stream_number", want.sid, got.sid);
      match("byte_offset", want.off, got.off);
      match("payload_length", want.plen, got.plen);
      match("fin_flag", want.fin, got.fin);
      match("length_given", want.lg, got.lg);
      match("payload_byte", want.pbyte, got.pbyte);
      match("frame_end", want.fend, got.fend);
      match("consumed_bytes", want.consumed, got.consumed);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_byte;
  logic               buffer_start;
  logic [LEN_W-1:0]   buffer_length;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         kind;
  logic [VALUE_W-1:0] stream_number;
  logic [VALUE_W-1:0] byte_offset;
  logic [VALUE_W-1:0] payload_length;
  logic               fin_flag;
  logic               length_given;
  logic [7:0]         payload_byte;
  logic               frame_end;
  logic [LEN_W-1:0]   consumed_bytes;

  frame_scoreboard sb;
  bit              idle_on;
  bit              hold_request;
  int              hold_left;
  int              work_items;

  stream_frame_header_parser DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 300000);
    $display("stream_frame_header_parser verification failed");
    $finish;
  end

  // receiver side: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end else if (hold_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 15);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({kind, stream_number, byte_offset, payload_length, fin_flag,
                       length_given, payload_byte, frame_end, consumed_bytes});
  end

  // entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic st, input logic [LEN_W-1:0] len);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    buffer_start  <= st;
    buffer_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.take_byte(b, st, len)) work_items++;
    @(negedge clk);
  endtask

  task automatic send_buffer(input logic [7:0] frame_bytes[$], input logic [LEN_W-1:0] declared,
                             input int count);
    for (int i = 0; i < count; i++)
      push_byte(i < frame_bytes.size() ? frame_bytes[i] : 8'($urandom), i == 0,
                i == 0 ? declared : LEN_W'($urandom));
  endtask

  function automatic void add_varint(ref logic [7:0] q[$], input logic [VALUE_W-1:0] value,
                                     input logic [1:0] code);
    int n;
    logic [63:0] w;
    n = 1 << code;
    w = {2'b00, value};
    if (n < 8) w = w & ((64'd1 << (8 * n - 2)) - 1);
    w = w | (64'(code) << (8 * n - 2));
    for (int i = n - 1; i >= 0; i--) q.push_back(w[8 * i +: 8]);
  endfunction

  function automatic logic [VALUE_W-1:0] any_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return VALUE_W'($urandom_range(0, 63));
      default: return VALUE_W'({$urandom, $urandom});
    endcase
  endfunction

  // mostly well-formed frames; the rest truncated, oversized length, abandoned or noise
  task automatic random_frame(input bit long_frame);
    logic [7:0]         q[$];
    logic [7:0]         head;
    logic [VALUE_W-1:0] lval;
    int                 pick;
    int                 plen;
    int                 declared;
    int                 count;
    int                 min_code;
    pick = long_frame ? 0 : $urandom_range(0, 99);
    if (pick >= 93) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0, LEN_W'($urandom));
      return;
    end
    head = 8'($urandom);
    if (long_frame || (pick >= 75 && pick < 85)) head[FLAG_LEN] = 1'b1;
    q.push_back(head);
    add_varint(q, any_value(), 2'($urandom));
    if (head[FLAG_OFF]) add_varint(q, any_value(), 2'($urandom));
    if (long_frame) plen = 48;
    else if ($urandom_range(0, 9) == 0) plen = $urandom_range(11, 60);
    else plen = $urandom_range(0, 10);
    if (head[FLAG_LEN]) begin
      lval = VALUE_W'(plen);
      if (pick >= 75 && pick < 85) begin
        if ($urandom_range(0, 3) == 0) lval = VALUE_W'({$urandom, $urandom}) | (62'd1 << 61);
        else lval = VALUE_W'(plen + $urandom_range(1, 3));
      end
      if (lval < 64) min_code = 0;
      else if (lval < 16384) min_code = 1;
      else if (lval < 62'h4000_0000) min_code = 2;
      else min_code = 3;
      add_varint(q, lval, 2'($urandom_range(min_code, 3)));
    end
    repeat (plen) q.push_back(8'($urandom));
    if (head[FLAG_LEN] && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
    declared = q.size();
    count = q.size();
    if (pick >= 65 && pick < 75) begin
      declared = $urandom_range(1, q.size() - 1);
      count = declared;
    end else if (pick >= 85) begin
      declared = $urandom_range(q.size(), 65535);
      count = $urandom_range(1, q.size());
    end
    send_buffer(q, LEN_W'(declared), count);
  endtask

  initial begin : stimulus
    logic [7:0] seq[$];
    int frames;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_byte       = 8'h00;
    buffer_start  = 1'b0;
    buffer_length = '0;
    idle_on       = 1'b1;
    hold_request  = 1'b0;
    work_items    = 0;
    sb = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // byte with no buffer open
    push_byte(8'hA5, 1'b0, 16'hFFFF);
    // type byte only, then zero length
    seq = '{8'h01};
    send_buffer(seq, 1, 1);
    seq = '{8'h07};
    send_buffer(seq, 0, 1);
    // no length field, payload runs to buffer end
    seq = '{8'h00, 8'h05, 8'hAB};
    send_buffer(seq, 3, 3);
    // empty payload with fin
    seq = '{8'h03, 8'h00, 8'h00};
    send_buffer(seq, 3, 3);
    // length and offset flags, unknown type bits, widest stream id
    seq = '{8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h3F, 8'h01, 8'h5A};
    send_buffer(seq, 12, 12);
    // buffer ends inside a varint
    seq = '{8'h04, 8'h40};
    send_buffer(seq, 2, 2);
    // offset needed but no bytes left
    seq = '{8'h04, 8'h05};
    send_buffer(seq, 2, 2);
    // declared length above what remains
    seq = '{8'h02, 8'h00, 8'h05};
    send_buffer(seq, 4, 3);

    work_items = 0;
    frames = 0;
    while (work_items < 650) begin
      if (frames == 15) begin
        hold_request = 1'b1;
        random_frame(1'b1);
      end else if (frames == 30) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        random_frame(1'b0);
      end else begin
        random_frame(1'b0);
      end
      if (work_items > 570) idle_on = 1'b0;
      frames++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0) $display("stream_frame_header_parser verification clean");
    else $display("stream_frame_header_parser verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sfhp_pkg.sv
rtl/core/sfhp_parse.sv
rtl/core/stream_frame_header_parser.sv
sim/stream_frame_header_parser_test.sv
